[design/txcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcw_pkg
// Shared types and constants of the text console writer: request codes,
// special characters, field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
package txcw_pkg;

   localparam int TYPE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int VALUE_W  = 16;
   localparam int CURCOL_W = 7;
   localparam int CURROW_W = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
   localparam logic [VALUE_W-1:0] BLANK_CELL   = 16'h0700;

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_EXEC   = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_SCR_RD = 8'b0001_0000,
      ST_SCR_WR = 8'b0010_0000,
      ST_FILL   = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec_op;
      logic read_latch;
      logic scr_read;
      logic scr_write;
      logic fill_write;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_put;
      logic is_clear;
      logic is_read;
      logic scroll_needed;
      logic shift_last;
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

[design/txcw_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcw_req_if / txcw_rsp_if
// Valid/ready channels for console requests and their responses.
// ----------------------------------------------------------------------------
interface txcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [txcw_pkg::TYPE_W-1:0]  req_type;
   logic [txcw_pkg::CHAR_W-1:0]  char_code;
   logic [txcw_pkg::ATTR_W-1:0]  attribute;
   logic [txcw_pkg::INDEX_W-1:0] cell_index;

   modport source (output valid, req_type, char_code, attribute, cell_index,
                   input ready);
   modport sink (input valid, req_type, char_code, attribute, cell_index,
                 output ready);
endinterface

interface txcw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [txcw_pkg::VALUE_W-1:0]  cell_value;
   logic [txcw_pkg::CURCOL_W-1:0] cursor_col;
   logic [txcw_pkg::CURROW_W-1:0] cursor_row;

   modport source (output valid, cell_value, cursor_col, cursor_row,
                   input ready);
   modport sink (input valid, cell_value, cursor_col, cursor_row,
                 output ready);
endinterface

[design/txcw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcw_ctrl
// Sequencer of the console: request intake, character write, scroll and
// blanking sweeps, and response hand-off.
// ----------------------------------------------------------------------------
module txcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  txcw_pkg::status_type status,
   output txcw_pkg::cmd_type    cmd
);

   txcw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= txcw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == txcw_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         txcw_pkg::ST_INIT: begin
            cmd.fill_write = 1'b1;
            if (status.sweep_last) begin
               state_in = txcw_pkg::ST_IDLE;
            end
         end
         txcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = txcw_pkg::ST_EXEC;
            end
         end
         txcw_pkg::ST_EXEC: begin
            cmd.exec_op = 1'b1;
            if (status.is_put && status.scroll_needed) begin
               state_in = txcw_pkg::ST_SCR_RD;
            end else if (status.is_clear) begin
               state_in = txcw_pkg::ST_FILL;
            end else if (status.is_read) begin
               state_in = txcw_pkg::ST_READ;
            end else begin
               state_in = txcw_pkg::ST_RESP;
            end
         end
         txcw_pkg::ST_READ: begin
            cmd.read_latch = 1'b1;
            state_in       = txcw_pkg::ST_RESP;
         end
         txcw_pkg::ST_SCR_RD: begin
            cmd.scr_read = 1'b1;
            state_in     = txcw_pkg::ST_SCR_WR;
         end
         txcw_pkg::ST_SCR_WR: begin
            cmd.scr_write = 1'b1;
            state_in = status.shift_last ? txcw_pkg::ST_FILL : txcw_pkg::ST_SCR_RD;
         end
         txcw_pkg::ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.sweep_last) begin
               state_in = txcw_pkg::ST_RESP;
            end
         end
         txcw_pkg::ST_RESP: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = txcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = txcw_pkg::ST_INIT;
         end
      endcase
   end

endmodule

[design/txcw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcw_dp
// Datapath of the console: request registers, cursor, screen store, sweep
// counter and the response register.
// ----------------------------------------------------------------------------
module txcw_dp #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  txcw_pkg::cmd_type             cmd,
   output txcw_pkg::status_type          status,
   input  logic [txcw_pkg::TYPE_W-1:0]   req_type,
   input  logic [txcw_pkg::CHAR_W-1:0]   char_code,
   input  logic [txcw_pkg::ATTR_W-1:0]   attribute,
   input  logic [txcw_pkg::INDEX_W-1:0]  cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [txcw_pkg::VALUE_W-1:0]  cell_value,
   output logic [txcw_pkg::CURCOL_W-1:0] cursor_col,
   output logic [txcw_pkg::CURROW_W-1:0] cursor_row
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] SHIFT_END  = ADDR_W'(CELLS - COLUMNS - 1);
   localparam logic [ADDR_W-1:0] SWEEP_END  = ADDR_W'(CELLS - 1);
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

   logic [txcw_pkg::VALUE_W-1:0] mem [CELLS];

   logic [txcw_pkg::TYPE_W-1:0]  type_ff;
   logic [txcw_pkg::CHAR_W-1:0]  char_ff;
   logic [txcw_pkg::ATTR_W-1:0]  attr_ff;
   logic [txcw_pkg::INDEX_W-1:0] idx_ff;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [ADDR_W-1:0]            cnt_ff, cnt_in;
   logic [txcw_pkg::VALUE_W-1:0] rdata_ff;
   logic [txcw_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                         out_valid_ff;
   logic [txcw_pkg::VALUE_W-1:0] out_value_ff;
   logic [COL_W-1:0]             out_col_ff;
   logic [ROW_W-1:0]             out_row_ff;

   logic                         is_newline, is_backspace, at_col_last, at_row_last;
   logic                         idx_in_range;
   logic [COL_W-1:0]             col_sel;
   logic [ADDR_W-1:0]            cur_addr;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr, rd_addr;
   logic [txcw_pkg::VALUE_W-1:0] wr_data;

   assign is_newline   = (char_ff == txcw_pkg::CH_NEWLINE);
   assign is_backspace = (char_ff == txcw_pkg::CH_BACKSPACE);
   assign at_col_last  = (col_ff == COL_LAST);
   assign at_row_last  = (row_ff == ROW_LAST);
   assign idx_in_range = (32'(idx_ff) < 32'(CELLS));

   assign col_sel  = (is_backspace && col_ff != '0) ? col_ff - COL_W'(1) : col_ff;
   assign cur_addr = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_sel);

   assign status.is_put        = (type_ff == txcw_pkg::REQ_PUT);
   assign status.is_clear      = (type_ff == txcw_pkg::REQ_CLEAR);
   assign status.is_read       = (type_ff == txcw_pkg::REQ_READ);
   assign status.scroll_needed = at_row_last &&
                                 (is_newline || (!is_backspace && at_col_last));
   assign status.shift_last    = (cnt_ff == SHIFT_END);
   assign status.sweep_last    = (cnt_ff == SWEEP_END);
   assign status.out_free      = !out_valid_ff || rsp_ready;

   // store port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = txcw_pkg::BLANK_CELL;
      rd_addr = ADDR_W'(idx_ff);
      if (cmd.exec_op && status.is_put && !is_newline) begin
         wr_en   = 1'b1;
         wr_addr = cur_addr;
         wr_data = is_backspace ? txcw_pkg::BLANK_CELL : {attr_ff, char_ff};
      end else if (cmd.scr_write) begin
         wr_en   = 1'b1;
         wr_data = rdata_ff;
      end else if (cmd.fill_write) begin
         wr_en = 1'b1;
      end
      if (cmd.scr_read) begin
         rd_addr = cnt_ff + COLS_A;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // cursor, counter and read value
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;
      if (cmd.exec_op) begin
         cnt_in   = '0;
         value_in = '0;
         if (status.is_clear) begin
            col_in = '0;
            row_in = '0;
         end else if (status.is_put) begin
            if (is_newline) begin
               col_in = '0;
               row_in = at_row_last ? row_ff : row_ff + ROW_W'(1);
            end else if (is_backspace) begin
               col_in = col_sel;
            end else if (at_col_last) begin
               col_in = '0;
               row_in = at_row_last ? row_ff : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
      if (cmd.scr_write || cmd.fill_write) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end
      if (cmd.read_latch) begin
         value_in = idx_in_range ? rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (cmd.capture) begin
         type_ff <= req_type;
         char_ff <= char_code;
         attr_ff <= attribute;
         idx_ff  <= cell_index;
      end
      if (cmd.load_out) begin
         out_value_ff <= value_ff;
         out_col_ff   <= col_ff;
         out_row_ff   <= row_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign cell_value = out_value_ff;
   assign cursor_col = txcw_pkg::CURCOL_W'(out_col_ff);
   assign cursor_row = txcw_pkg::CURROW_W'(out_row_ff);

endmodule

[design/text_console_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: character cells, cursor, scroll and clear.
// Requests are taken one at a time: req is ready only when idle, and a new
//   request is taken after the response to the last one is loaded.
// Scroll and clear run as store sweeps, which hold off the next request:
//   the store sweep moves or blanks one cell per step through one write port.
// Reset: synchronous; the store is blanked after reset with req not ready.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   txcw_req_if.sink   req_bus,
   txcw_rsp_if.source rsp_bus
);

   txcw_pkg::cmd_type    cmd;
   txcw_pkg::status_type status;

   txcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   txcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_type   (req_bus.req_type),
      .char_code  (req_bus.char_code),
      .attribute  (req_bus.attribute),
      .cell_index (req_bus.cell_index),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .cell_value (rsp_bus.cell_value),
      .cursor_col (rsp_bus.cursor_col),
      .cursor_row (rsp_bus.cursor_row)
   );

`ifndef SYNTH
   a_one_beat_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request accepted while previous one still in work");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> 32'(rsp_bus.cursor_col) < 32'(COLUMNS))
      else $error("cursor column beyond last column");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> 32'(rsp_bus.cursor_row) < 32'(ROWS))
      else $error("cursor row beyond last row");
`endif

endmodule
